[hw/rtl/mbps_pkg.sv]
// Package for the masked byte pattern search core.
// Holds the word types, the configuration register map and sizing constants.
// No dependencies.
package mbps_pkg;

  // Sizing: pattern window depth and width of the byte counter
  localparam int unsigned PATTERN_MAX = 32;
  localparam int unsigned OFFSET_BITS = 32;
  localparam int unsigned WinIdxW     = $clog2(PATTERN_MAX);
  localparam int unsigned LenW        = 6;
  localparam int unsigned OffsetW     = 32;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 64;
  localparam int unsigned PatWords    = 4;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PATTERN_LENGTH  = 3'd0,
    CFG_PATTERN_BYTES_0 = 3'd1,
    CFG_PATTERN_BYTES_1 = 3'd2,
    CFG_PATTERN_BYTES_2 = 3'd3,
    CFG_PATTERN_BYTES_3 = 3'd4,
    CFG_WILDCARD_MASK   = 3'd5
  } cfg_idx_e;

  // Input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       region_end;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic               match_found;
    logic [OffsetW-1:0] match_offset;
  } out_word_t;

  // Configuration state seen by the matcher
  typedef struct packed {
    logic [LenW-1:0]                    pattern_length;
    logic [PatWords-1:0][CfgDataW-1:0]  pattern_bytes;
    logic [31:0]                        wildcard_mask;
  } cfg_t;

  // Per-step result from the matcher
  typedef struct packed {
    logic      valid;
    out_word_t word;
  } res_t;

endpackage

[hw/rtl/mbps_cfg_regs.sv]
// Configuration register file of the masked byte pattern search core.
// Decodes index writes into the pattern, length and wildcard registers.
// Depends on mbps_pkg.
module mbps_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [mbps_pkg::CfgIdxW-1:0]  wr_index_i,
  input  logic [mbps_pkg::CfgDataW-1:0] wr_data_i,
  output mbps_pkg::cfg_t                cfg_o
);

  mbps_pkg::cfg_t cfg_q;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_length <= mbps_pkg::LenW'(1);
      cfg_q.pattern_bytes  <= '0;
      cfg_q.wildcard_mask  <= '0;
    end else if (wr_en_i) begin
      case (wr_index_i)
        mbps_pkg::CFG_PATTERN_LENGTH:  cfg_q.pattern_length   <= wr_data_i[mbps_pkg::LenW-1:0];
        mbps_pkg::CFG_PATTERN_BYTES_0: cfg_q.pattern_bytes[0] <= wr_data_i;
        mbps_pkg::CFG_PATTERN_BYTES_1: cfg_q.pattern_bytes[1] <= wr_data_i;
        mbps_pkg::CFG_PATTERN_BYTES_2: cfg_q.pattern_bytes[2] <= wr_data_i;
        mbps_pkg::CFG_PATTERN_BYTES_3: cfg_q.pattern_bytes[3] <= wr_data_i;
        mbps_pkg::CFG_WILDCARD_MASK:   cfg_q.wildcard_mask    <= wr_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/mbps_matcher.sv]
// Window, byte counter and parallel compare of the pattern search core.
// One step per word of an unmatched region: shift the window, bump the count, test every position.
// Depends on mbps_pkg.
module mbps_matcher (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  mbps_pkg::in_word_t word_i,
  input  mbps_pkg::cfg_t     cfg_i,
  output mbps_pkg::res_t     res_o
);

  localparam int unsigned CntW = mbps_pkg::OFFSET_BITS;

  logic [mbps_pkg::PATTERN_MAX-1:0][7:0] win_q, win_d;
  logic [CntW-1:0]                       seen_q, seen_d, seen_inc;
  logic                                  matched_q, matched_d;

  logic [mbps_pkg::LenW-1:0]             len_eff;
  logic [31:0][7:0]                      pat;
  logic [mbps_pkg::PATTERN_MAX-1:0]      hit;
  logic                                  long_enough;
  logic                                  is_match;
  logic [CntW-1:0]                       start_off;
  logic [mbps_pkg::LenW-1:0]             pos_idx [mbps_pkg::PATTERN_MAX];

  // Clamp pattern length to 1..PATTERN_MAX
  always_comb begin
    if (cfg_i.pattern_length == '0) begin
      len_eff = mbps_pkg::LenW'(1);
    end else if (cfg_i.pattern_length > mbps_pkg::LenW'(mbps_pkg::PATTERN_MAX)) begin
      len_eff = mbps_pkg::LenW'(mbps_pkg::PATTERN_MAX);
    end else begin
      len_eff = cfg_i.pattern_length;
    end
  end

  assign pat      = cfg_i.pattern_bytes;
  assign win_d    = {win_q[mbps_pkg::PATTERN_MAX-2:0], word_i.data_byte};
  assign seen_inc = (seen_q == '1) ? seen_q : seen_q + CntW'(1);

  // Window slot k (newest first) lines up with pattern byte len-1-k
  always_comb begin
    for (int k = 0; k < mbps_pkg::PATTERN_MAX; k++) begin
      pos_idx[k] = len_eff - mbps_pkg::LenW'(1) - mbps_pkg::LenW'(k);
      if (mbps_pkg::LenW'(k) >= len_eff) begin
        hit[k] = 1'b1;
      end else begin
        hit[k] = cfg_i.wildcard_mask[pos_idx[k][4:0]] ||
                 (pat[pos_idx[k][4:0]] == win_d[k]);
      end
    end
  end

  assign long_enough = seen_inc >= CntW'(len_eff);
  assign is_match    = long_enough && (&hit);
  assign start_off   = seen_inc - CntW'(len_eff);

  // Result of this step
  always_comb begin
    res_o.valid             = 1'b0;
    res_o.word.match_found  = 1'b0;
    res_o.word.match_offset = '0;
    if (step_i && !matched_q) begin
      if (is_match) begin
        res_o.valid             = 1'b1;
        res_o.word.match_found  = 1'b1;
        res_o.word.match_offset = mbps_pkg::OffsetW'(start_off);
      end else if (word_i.region_end) begin
        res_o.valid = 1'b1;
      end
    end
  end

  // Count and match flag; region end starts a fresh region
  always_comb begin
    seen_d    = seen_q;
    matched_d = matched_q;
    if (step_i) begin
      if (!matched_q) begin
        seen_d    = seen_inc;
        matched_d = is_match;
      end
      if (word_i.region_end) begin
        seen_d    = '0;
        matched_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= '0;
      matched_q <= 1'b0;
    end else begin
      seen_q    <= seen_d;
      matched_q <= matched_d;
    end
  end

  // Window shifts only while the region is still being searched
  always_ff @(posedge clk_i) begin
    if (step_i && !matched_q) begin
      win_q <= win_d;
    end
  end

  // Once matched, the rest of the region stays silent
  a_silent_after_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    matched_q |-> !res_o.valid)
    else $error("result produced after a match in the same region");

  // A found result mid-region latches the match flag
  a_match_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.valid && res_o.word.match_found && !word_i.region_end |=> matched_q)
    else $error("match flag not set after a found result");

  // Region end clears the count and the match flag
  a_region_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && word_i.region_end |=> (seen_q == '0) && !matched_q)
    else $error("region state not cleared at region end");

endmodule

[hw/rtl/masked_byte_pattern_search_core.sv]
// Searches a byte stream for a masked pattern of up to PATTERN_MAX bytes and
// reports the start offset of the first match in each region, or a not-found
// word on the region's last byte if no match occurs. One byte word is taken
// every clock cycle while the result side does not stall; the result for a
// byte passes the input register, then the compare and the result register.
// The full window is compared against the clamped pattern in parallel between
// the two registers, which sets the one-word-per-cycle rate. Configuration
// writes are always accepted and must be issued while no word is in flight.
// Depends on mbps_pkg, mbps_cfg_regs and mbps_matcher.
module masked_byte_pattern_search_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // byte input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mbps_pkg::in_word_t            in_data_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mbps_pkg::out_word_t           out_data_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mbps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mbps_pkg::CfgDataW-1:0] cfg_data_i
);

  mbps_pkg::cfg_t      cfg;
  mbps_pkg::res_t      res;
  mbps_pkg::in_word_t  s1_word_q;
  logic                s1_valid_q;
  mbps_pkg::out_word_t out_word_q;
  logic                out_valid_q;
  logic                adv;
  logic                in_acc;

  assign cfg_ready_o = 1'b1;

  mbps_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Stage 1 moves on whenever the result register is free or draining
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  mbps_matcher u_match (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_valid_q && adv),
    .word_i (s1_word_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!s1_valid_q || adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_word_q <= in_data_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q && res.valid) begin
      out_word_q <= res.word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

endmodule

[bench/masked_byte_pattern_search_core_test.sv]
// Self-checking testbench for masked_byte_pattern_search_core.
// Streams byte regions with embedded, cut-short and corrupted patterns, predicts each
// result word in step with the block, and checks it. Depends on mbps_pkg and the core.
module masked_byte_pattern_search_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mbps_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned IdlePercent  = 31;
  // indexes past the register map; writes there must be dropped
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 3'd7;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_word_t            in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_word_t           out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Predictor state: config mirror and scan state
  logic [LenW-1:0]                   cur_len  = LenW'(1);
  logic [PatWords-1:0][CfgDataW-1:0] cur_pat  = '0;
  logic [31:0]                       cur_mask = '0;
  logic [7:0]                        scan_window [PATTERN_MAX];
  logic [OFFSET_BITS-1:0]            scan_count   = '0;
  bit                                scan_matched = 1'b0;
  out_word_t                         expected_hits [$];

  // Stimulus-side copy of the pattern in use
  int unsigned                       gen_len;
  logic [PatWords-1:0][CfgDataW-1:0] gen_pat;
  logic [31:0]                       gen_mask;

  bit          quiet = 1'b0;
  int unsigned words_sent  = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  masked_byte_pattern_search_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Clamp the raw length register to 1..PATTERN_MAX
  function automatic int unsigned eff_len(logic [LenW-1:0] raw);
    if (raw == 0) return 1;
    if (raw > PATTERN_MAX) return PATTERN_MAX;
    return raw;
  endfunction

  function automatic logic [7:0] pattern_byte_at(logic [PatWords-1:0][CfgDataW-1:0] pat,
                                                 int unsigned j);
    return pat[j / 8][8 * (j % 8) +: 8];
  endfunction

  // Newest byte sits at index 0, so pattern byte j lines up with n-1-j
  function automatic bit window_hit(int unsigned n);
    for (int unsigned j = 0; j < n; j++) begin
      if (!cur_mask[j] && pattern_byte_at(cur_pat, j) != scan_window[n - 1 - j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    error_count++;
  endtask

  // Predictor: tracks config writes and accepted byte words
  always @(posedge clk_i) begin : predict_scan
    in_word_t    w;
    out_word_t   hit;
    int unsigned n;
    int unsigned k;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_PATTERN_LENGTH:  cur_len     = cfg_data_i[LenW-1:0];
          CFG_PATTERN_BYTES_0: cur_pat[0]  = cfg_data_i;
          CFG_PATTERN_BYTES_1: cur_pat[1]  = cfg_data_i;
          CFG_PATTERN_BYTES_2: cur_pat[2]  = cfg_data_i;
          CFG_PATTERN_BYTES_3: cur_pat[3]  = cfg_data_i;
          CFG_WILDCARD_MASK:   cur_mask    = cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        w = in_data_i;
        if (!scan_matched) begin
          n = eff_len(cur_len);
          for (k = PATTERN_MAX - 1; k > 0; k--) scan_window[k] = scan_window[k - 1];
          scan_window[0] = w.data_byte;
          if (scan_count != '1) scan_count++;
          if (scan_count >= n && window_hit(n)) begin
            hit.match_found  = 1'b1;
            hit.match_offset = OffsetW'(scan_count - OFFSET_BITS'(n));
            expected_hits.push_back(hit);
            scan_matched = 1'b1;
          end else if (w.region_end) begin
            hit.match_found  = 1'b0;
            hit.match_offset = '0;
            expected_hits.push_back(hit);
          end
        end
        // a region end always opens a fresh region
        if (w.region_end) begin
          scan_count   = '0;
          scan_matched = 1'b0;
        end
      end
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin : check_results
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_hits.size() == 0) begin
        report_mismatch($sformatf("unexpected word found=%0b offset=%0d",
                                  out_data_o.match_found, out_data_o.match_offset));
      end else begin
        want = expected_hits.pop_front();
        if (out_data_o.match_found !== want.match_found)
          report_mismatch($sformatf("match_found %0b, expected %0b",
                                    out_data_o.match_found, want.match_found));
        if (out_data_o.match_offset !== want.match_offset)
          report_mismatch($sformatf("match_offset %0d, expected %0d",
                                    out_data_o.match_offset, want.match_offset));
      end
    end
  end

  // Random back-pressure on the result side
  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < IdlePercent);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Send one byte word; valid stays high on return so back-to-back words need no toggle
  task automatic send_word(input in_word_t w);
    while (!quiet && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  // Stop sending, wait out every pending result, then let the pipe settle
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Program the whole register set, plus one write to an unmapped index
  task automatic set_pattern(input logic [CfgDataW-1:0] len_word,
                             input logic [PatWords-1:0][CfgDataW-1:0] pat,
                             input logic [31:0] mask);
    gen_len  = eff_len(len_word[LenW-1:0]);
    gen_pat  = pat;
    gen_mask = mask;
    write_reg(CFG_PATTERN_LENGTH, len_word);
    write_reg(CFG_PATTERN_BYTES_0, pat[0]);
    write_reg(CFG_PATTERN_BYTES_1, pat[1]);
    write_reg(CFG_PATTERN_BYTES_2, pat[2]);
    write_reg(CFG_PATTERN_BYTES_3, pat[3]);
    write_reg($urandom_range(1) ? CfgIdxSpareHi : CfgIdxSpareLo, {$urandom, $urandom});
    write_reg(CFG_WILDCARD_MASK, {$urandom, mask});
    cfg_valid_i <= 1'b0;
  endtask

  // Random pattern bytes, junk in the unused length bits
  task automatic random_pattern(input logic [LenW-1:0] len_raw, input logic [31:0] mask);
    logic [PatWords-1:0][CfgDataW-1:0] pat;
    logic [CfgDataW-1:0]               len_word;
    for (int i = 0; i < PatWords; i++) pat[i] = {$urandom, $urandom};
    len_word = {$urandom, $urandom};
    len_word[LenW-1:0] = len_raw;
    set_pattern(len_word, pat, mask);
  endtask

  // Half the noise is drawn from the pattern itself to provoke near misses
  function automatic logic [7:0] noise_byte();
    if ($urandom_range(1)) return 8'($urandom);
    return pattern_byte_at(gen_pat, $urandom_range(gen_len - 1));
  endfunction

  function automatic logic [7:0] pattern_pick(int unsigned j, bit corrupt);
    logic [7:0] b;
    b = pattern_byte_at(gen_pat, j);
    if (gen_mask[j]) return 8'($urandom);
    if (corrupt) return b ^ 8'($urandom_range(255, 1));
    return b;
  endfunction

  // One region: noise, maybe a (possibly cut or corrupted) pattern copy, noise
  task automatic send_region();
    logic [7:0]  body [$];
    int unsigned pre, post, keep, flip, j;
    in_word_t    w;
    pre = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
    repeat (pre) body.push_back(noise_byte());
    if ($urandom_range(99) < 70) begin
      keep = ($urandom_range(4) == 0) ? $urandom_range(gen_len - 1) : gen_len;
      flip = ($urandom_range(6) == 0) ? $urandom_range(gen_len - 1) : gen_len;
      for (j = 0; j < keep; j++) body.push_back(pattern_pick(j, j == flip));
      post = ($urandom_range(2) == 0) ? 0 : $urandom_range(6);
      repeat (post) body.push_back(noise_byte());
    end
    if (body.size() == 0) body.push_back(noise_byte());
    for (j = 0; j < body.size(); j++) begin
      w.data_byte  = body[j];
      w.region_end = (j == body.size() - 1);
      send_word(w);
    end
  endtask

  task automatic run_regions(input int unsigned n_words);
    int unsigned start;
    start = words_sent;
    while (words_sent - start < n_words) send_region();
    wait_results_drained();
  endtask

  task automatic send_bytes(input logic [7:0] bytes [$]);
    in_word_t w;
    for (int unsigned j = 0; j < bytes.size(); j++) begin
      w.data_byte  = bytes[j];
      w.region_end = (j == bytes.size() - 1);
      send_word(w);
    end
  endtask

  // Reset config: one-byte pattern 0x00, no wildcards
  task automatic test_reset_values();
    send_bytes('{8'h00});
    send_bytes('{8'hFF});
    send_bytes('{8'h00, 8'h00});
    wait_results_drained();
  endtask

  // Pattern FF ? 00: hit on the final byte, short region, ignored tail, one-byte region
  task automatic test_wildcard_directed();
    logic [PatWords-1:0][CfgDataW-1:0] pat;
    pat    = {{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, 64'h0};
    pat[0] = {40'hFF_FFFF_FFFF, 24'h0033FF};
    set_pattern({58'h3FF_FFFF_FFFF_FFFF, 6'd3}, pat, 32'h0000_0002);
    send_bytes('{8'h00, 8'hFF, 8'h5A, 8'h00});
    send_bytes('{8'hFF, 8'h00});
    send_bytes('{8'hFF, 8'h11, 8'h00, 8'hFF, 8'h22, 8'h00});
    send_bytes('{8'h00});
    wait_results_drained();
  endtask

  // Length register 0 acts as 1, values past the window depth act as full depth
  task automatic test_length_clamping();
    random_pattern(6'd0, 32'h0);
    run_regions(70);
    random_pattern(6'd63, $urandom & $urandom);
    run_regions(70);
  endtask

  // Full-depth pattern, all wildcards then none
  task automatic test_full_window();
    random_pattern(6'd32, 32'hFFFF_FFFF);
    run_regions(70);
    random_pattern(6'd32, 32'h0);
    run_regions(80);
  endtask

  // Random lengths and masks; one phase runs without any idle cycles
  task automatic test_random_patterns();
    random_pattern(6'd1, 32'h0000_0001);
    run_regions(30);
    for (int p = 0; p < 4; p++) begin
      quiet = (p == 2);
      random_pattern(6'($urandom_range(32, 1)), $urandom & $urandom);
      run_regions(75);
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_stall_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    gen_len     = 1;
    gen_pat     = '0;
    gen_mask    = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_wildcard_directed();
    test_length_clamping();
    test_full_window();
    test_random_patterns();

    wait_results_drained();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
